// ===== sv/rbv_pkg.sv =====
package rbv_pkg;

  localparam int LINE_LENGTH   = 264;
  localparam int LINE_TOTAL    = 628;
  localparam int FRAME_LINE    = 602;
  localparam int ACTIVE_WIDTH  = 200;
  localparam int ACTIVE_HEIGHT = 150;
  localparam int HALF_WIDTH    = ACTIVE_WIDTH / 2;
  localparam int MEM_DEPTH     = 32768;
  localparam int MEM_AW        = $clog2(MEM_DEPTH);
  localparam int PAL_ENTRIES   = 16;

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

  localparam logic [7:0] PORT_ADDR_HI  = 8'h10;
  localparam logic [7:0] PORT_ADDR_LO  = 8'h11;
  localparam logic [7:0] PORT_VRAM     = 8'h12;
  localparam logic [7:0] PORT_PAL_PTR  = 8'h20;
  localparam logic [7:0] PORT_PAL_DATA = 8'h21;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_TICK,
    OP_VWR,
    OP_PWR
  } op_kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] port;
    logic [7:0] wdata;
  } item_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_done;
  } result_t;

  typedef struct packed {
    op_kind_e          kind;
    logic              pix_valid;
    logic              nib_hi;
    logic              frame_done;
    logic [7:0]        x;
    logic [7:0]        y;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
    logic [3:0]        pal_entry;
    logic [1:0]        pal_comp;
  } op_t;

endpackage

// ===== sv/rbv_ram.sv =====
module rbv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/rbv_front.sv =====
module rbv_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  rbv_pkg::item_t item_i,
  output rbv_pkg::op_t   op_o
);
  import rbv_pkg::*;

  logic [8:0]  col_q, col_d;
  logic [9:0]  line_q, line_d;
  logic [15:0] mptr_q, mptr_d;
  logic [7:0]  pptr_q, pptr_d;

  logic [8:0]  col_n;
  logic [9:0]  line_n;
  logic        wrap;
  logic [15:0] raddr;
  logic [15:0] div_prod;
  logic [6:0]  pal_entry;
  logic [7:0]  pal_rem;

  // Reduce a 16-bit address into the memory range by repeated subtraction.
  function automatic logic [MEM_AW-1:0] mem_mod(input logic [15:0] v);
    logic [16:0] r;
    r = {1'b0, v};
    for (int k = 0; k < 4; k++) begin
      if (r >= 17'(MEM_DEPTH)) begin
        r = r - 17'(MEM_DEPTH);
      end
    end
    return r[MEM_AW-1:0];
  endfunction

  assign col_n  = col_q + 9'd1;
  assign line_n = line_q + 10'd1;
  assign wrap   = col_n >= 9'(LINE_LENGTH);
  assign raddr  = 16'(line_q[7:0]) * 16'(HALF_WIDTH) + 16'(col_n[8:1]);

  // Divide the palette pointer by three with a reciprocal multiply.
  assign div_prod  = 16'(pptr_q) * 16'd171;
  assign pal_entry = div_prod[15:9];
  assign pal_rem   = pptr_q - {pal_entry, 1'b0} - {1'b0, pal_entry};

  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    mptr_d = mptr_q;
    pptr_d = pptr_q;
    op_o   = '0;
    op_o.kind = OP_NOP;
    if (item_i.action == ACT_TICK) begin
      op_o.kind      = OP_TICK;
      op_o.pix_valid = (col_n < 9'(ACTIVE_WIDTH)) && (line_q < 10'(ACTIVE_HEIGHT));
      op_o.nib_hi    = col_n[0];
      op_o.x         = col_n[7:0];
      op_o.y         = line_q[7:0];
      op_o.addr      = mem_mod(raddr);
      col_d          = col_n;
      if (wrap) begin
        col_d           = '0;
        line_d          = line_n;
        op_o.frame_done = line_n == 10'(FRAME_LINE);
        if (line_n >= 10'(LINE_TOTAL)) begin
          line_d = '0;
        end
      end
    end else begin
      case (item_i.port)
        PORT_ADDR_HI: begin
          mptr_d = {item_i.wdata, mptr_q[7:0]};
        end
        PORT_ADDR_LO: begin
          mptr_d = {mptr_q[15:8], item_i.wdata};
        end
        PORT_VRAM: begin
          op_o.kind = OP_VWR;
          op_o.addr = mem_mod(mptr_q);
          op_o.data = item_i.wdata;
          mptr_d    = mptr_q + 16'd1;
        end
        PORT_PAL_PTR: begin
          pptr_d = item_i.wdata;
        end
        PORT_PAL_DATA: begin
          if (pal_entry[6:4] == 3'd0) begin
            op_o.kind      = OP_PWR;
            op_o.pal_entry = pal_entry[3:0];
            op_o.pal_comp  = pal_rem[1:0];
            op_o.data      = {item_i.wdata[4:0], 3'b000};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
      mptr_q <= '0;
      pptr_q <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      line_q <= line_d;
      mptr_q <= mptr_d;
      pptr_q <= pptr_d;
    end
  end

endmodule

// ===== sv/rbv_opq.sv =====
module rbv_opq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  rbv_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output rbv_pkg::op_t op_o,
  output logic         empty_o
);
  import rbv_pkg::*;

  op_t             slot_q [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_q, rd_q;
  logic [OPQ_AW:0]   cnt_q;

  assign full_o  = cnt_q == (OPQ_AW + 1)'(OPQ_DEPTH);
  assign empty_o = cnt_q == '0;
  assign op_o    = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + OPQ_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + OPQ_AW'(1);
      end
      cnt_q <= cnt_q + (OPQ_AW + 1)'(push_i) - (OPQ_AW + 1)'(pop_i);
    end
  end

endmodule

// ===== sv/rbv_back.sv =====
module rbv_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rbv_pkg::op_t     op_i,
  input  logic             op_valid_i,
  output logic             op_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rbv_pkg::result_t result_o,
  output logic             clearing_o
);
  import rbv_pkg::*;

  logic [MEM_AW-1:0] clr_q;
  logic              clearing_q;
  logic              b_valid_q;
  op_t               b_op_q;
  logic              out_valid_q;
  result_t           out_q;
  logic [7:0]        pal_q [PAL_ENTRIES][3];

  logic              b_adv;
  logic              issue;
  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;
  logic [3:0]        nib;
  result_t           res;

  // Fixed power-up palette.
  function automatic logic [23:0] default_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = {8'd0,   8'd0,   8'd0};
      4'd1:    rgb = {8'd122, 8'd0,   8'd0};
      4'd2:    rgb = {8'd0,   8'd122, 8'd0};
      4'd3:    rgb = {8'd0,   8'd0,   8'd122};
      4'd4:    rgb = {8'd122, 8'd122, 8'd0};
      4'd5:    rgb = {8'd122, 8'd0,   8'd122};
      4'd6:    rgb = {8'd0,   8'd122, 8'd122};
      4'd7:    rgb = {8'd170, 8'd170, 8'd170};
      4'd8:    rgb = {8'd85,  8'd85,  8'd85};
      4'd9:    rgb = {8'd255, 8'd0,   8'd0};
      4'd10:   rgb = {8'd0,   8'd255, 8'd0};
      4'd11:   rgb = {8'd0,   8'd0,   8'd255};
      4'd12:   rgb = {8'd255, 8'd255, 8'd0};
      4'd13:   rgb = {8'd255, 8'd0,   8'd255};
      4'd14:   rgb = {8'd0,   8'd255, 8'd255};
      default: rgb = {8'd255, 8'd255, 8'd255};
    endcase
    return rgb;
  endfunction

  assign b_adv    = b_valid_q && (!out_valid_q || pop_i);
  assign issue    = op_valid_i && !clearing_q && (!b_valid_q || b_adv);
  assign op_pop_o = issue;

  // Memory accesses happen in op order at issue; the clear sweep owns the port.
  assign ram_we    = clearing_q || (issue && (op_i.kind == OP_VWR));
  assign ram_waddr = clearing_q ? clr_q : op_i.addr;
  assign ram_wdata = clearing_q ? 8'd0 : op_i.data;
  assign ram_re    = issue && (op_i.kind == OP_TICK) && op_i.pix_valid;

  rbv_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_vram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(op_i.addr),
    .rdata_o(ram_rdata)
  );

  assign nib = b_op_q.nib_hi ? ram_rdata[7:4] : ram_rdata[3:0];

  always_comb begin
    res = '0;
    if (b_op_q.kind == OP_TICK) begin
      res.frame_done = b_op_q.frame_done;
      if (b_op_q.pix_valid) begin
        res.pixel_valid = 1'b1;
        res.pixel_x     = b_op_q.x;
        res.pixel_y     = b_op_q.y;
        res.red         = pal_q[nib][0];
        res.green       = pal_q[nib][1];
        res.blue        = pal_q[nib][2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_op_q <= op_i;
    end
    if (b_adv) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      clearing_q  <= 1'b1;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int e = 0; e < PAL_ENTRIES; e++) begin
        {pal_q[e][0], pal_q[e][1], pal_q[e][2]} <= default_rgb(4'(e));
      end
    end else begin
      if (clearing_q) begin
        clr_q <= clr_q + MEM_AW'(1);
        if (clr_q == MEM_AW'(MEM_DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (issue) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      // Palette writes land when their beat leaves, after any earlier lookup.
      if (b_adv && (b_op_q.kind == OP_PWR)) begin
        pal_q[b_op_q.pal_entry][b_op_q.pal_comp] <= b_op_q.data;
      end
    end
  end

  assign empty_o    = !out_valid_q;
  assign result_o   = out_q;
  assign clearing_o = clearing_q;

endmodule

// ===== sv/raster_bitmap_video_unit.sv =====
// Path: a beat goes through the op queue, the issue stage and the result register.
// Throughput: one beat per cycle when not stalled, set by the single RAM issue slot.
// Reset: counters, pointers and queues clear at once and the palette reloads its
// default table; video RAM is then zeroed by a sweep over all 32768 addresses, one
// address per cycle, while full stays high.
module raster_bitmap_video_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  rbv_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output rbv_pkg::result_t result_o
);
  import rbv_pkg::*;

  logic accept;
  op_t  fe_op;
  op_t  q_op;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic clearing;

  // Take a beat only when the op queue has room and the RAM sweep is done.
  assign full   = q_full || clearing;
  assign accept = push && !full;

  // Front: raster counters and port registers; classify each beat into an op.
  rbv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .item_i  (item_i),
    .op_o    (fe_op)
  );

  // Short op queue decouples input stalls from output stalls.
  rbv_opq u_opq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .op_i   (fe_op),
    .full_o (q_full),
    .pop_i  (q_pop),
    .op_o   (q_op),
    .empty_o(q_empty)
  );

  // Back: video RAM access, palette lookup and update, result register.
  rbv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (q_op),
    .op_valid_i(!q_empty),
    .op_pop_o  (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o),
    .clearing_o(clearing)
  );

  // A line wrap lies outside the active area, so no pixel carries frame done.
  a_frame_not_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(result_o.pixel_valid && result_o.frame_done))
    else $error("frame done on a visible pixel");

  // A blank result carries no colour or position.
  a_blank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.pixel_valid) |->
      (result_o.red == 8'd0 && result_o.green == 8'd0 && result_o.blue == 8'd0 &&
       result_o.pixel_x == 8'd0 && result_o.pixel_y == 8'd0))
    else $error("blank result with nonzero payload");

  // No op leaves the queue while the RAM sweep runs.
  a_no_issue_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !q_pop)
    else $error("op issued during RAM clear");

  // An unpopped result stays put.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("result changed while stalled");

endmodule
